### hw/rtl/tsp_pkg.sv
package tsp_pkg;

    localparam int COORD_W          = 16;
    localparam int SIZE_W           = 8;
    localparam int PROD_W           = COORD_W + SIZE_W + 1;
    localparam int TEXEL_W          = 32;
    localparam int WCOORD_W         = 7;
    localparam int CHAN_W           = 8;
    localparam int FRAC_W           = 8;
    localparam int NUM_CHAN         = 4;
    localparam int NUM_BANKS        = 4;
    localparam int QUEUE_DEPTH      = 4;
    localparam int DEF_MAX_WIDTH    = 128;
    localparam int DEF_MAX_HEIGHT   = 128;
    localparam int DEF_UV_FRAC_BITS = 12;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    localparam logic MODE_POINT    = 1'b0;
    localparam logic MODE_BILINEAR = 1'b1;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_MODE   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic                       kind;
        logic signed [COORD_W-1:0]  u_coord;
        logic signed [COORD_W-1:0]  v_coord;
        logic [WCOORD_W-1:0]        write_x;
        logic [WCOORD_W-1:0]        write_y;
        logic [CHAN_W-1:0]          write_red;
        logic [CHAN_W-1:0]          write_green;
        logic [CHAN_W-1:0]          write_blue;
        logic [CHAN_W-1:0]          write_alpha;
    } req_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_alpha;
    } rsp_t;

    // effective sizes and filter mode
    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic              mode;
    } cfg_t;

    // classified request handed from front to back
    typedef struct packed {
        logic                       kind;
        logic signed [PROD_W-1:0]   sx;
        logic signed [PROD_W-1:0]   sy;
        logic [WCOORD_W-1:0]        wx;
        logic [WCOORD_W-1:0]        wy;
        logic [TEXEL_W-1:0]         texel;
    } entry_t;

endpackage

### hw/rtl/tsp_front.sv
module tsp_front
    import tsp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   req_valid,
    output logic   req_ready,
    input  req_t   req,
    input  cfg_t   cfg,
    input  logic   q_full,
    output logic   q_push,
    output entry_t q_entry
);

    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;
    entry_t entry_next;
    logic   accept;

    assign q_push    = valid_reg && !q_full;
    assign req_ready = !valid_reg || !q_full;
    assign accept    = req_valid && req_ready;
    assign q_entry   = entry_reg;

    always_comb
    begin
        valid_next = accept ? 1'b1 : (q_push ? 1'b0 : valid_reg);
        entry_next.kind  = req.kind;
        // scale coordinates by the texture size
        entry_next.sx    = PROD_W'(req.u_coord)
                         * $signed({{(PROD_W-SIZE_W){1'b0}}, cfg.width});
        entry_next.sy    = PROD_W'(req.v_coord)
                         * $signed({{(PROD_W-SIZE_W){1'b0}}, cfg.height});
        entry_next.wx    = req.write_x;
        entry_next.wy    = req.write_y;
        entry_next.texel = {req.write_alpha, req.write_blue, req.write_green, req.write_red};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

### hw/rtl/tsp_queue.sv
module tsp_queue
    import tsp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   empty,
    output entry_t pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");
    a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow on push");

endmodule

### hw/rtl/tsp_back.sv
module tsp_back
    import tsp_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
    parameter int UV_FRAC_BITS = DEF_UV_FRAC_BITS
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   q_empty,
    input  entry_t q_entry,
    output logic   q_pop,
    output logic   rsp_valid,
    input  logic   rsp_ready,
    output rsp_t   rsp
);

    localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
    localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = HALF_W * HALF_H;
    localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam logic signed [PROD_W-1:0] HALF_TEXEL =
        PROD_W'(longint'(1) << (UV_FRAC_BITS - 1));

    function automatic logic [SIZE_W-1:0] clamp_coord(
        input logic signed [PROD_W-1:0] v,
        input logic [SIZE_W-1:0]        size
    );
        logic signed [PROD_W-1:0] lim;
        lim = $signed({{(PROD_W-SIZE_W){1'b0}}, size});
        if (v < 0)
            return '0;
        else if (v >= lim)
            return size - 1'b1;
        else
            return v[SIZE_W-1:0];
    endfunction

    function automatic logic [BAW-1:0] bank_addr(
        input logic [SIZE_W-1:0] col,
        input logic [SIZE_W-1:0] row
    );
        return BAW'(32'(row >> 1) * HALF_W + 32'(col >> 1));
    endfunction

    logic advance;

    // stage 1: texel addresses
    logic signed [PROD_W-1:0] hx, hy, xi, yi;
    logic [SIZE_W-1:0]        x0, x1, y0, y1;
    logic                     wr_ok;
    logic [BAW-1:0]           waddr;
    logic [BAW-1:0]           addr_next [NUM_BANKS];
    logic [3:0]               sel_next;
    logic [FRAC_W-1:0]        fx_next, fy_next;

    logic                     s1_valid_reg;
    logic                     s1_kind_reg;
    logic                     s1_wr_reg;
    logic [1:0]               s1_wbank_reg;
    logic [TEXEL_W-1:0]       s1_texel_reg;
    logic [BAW-1:0]           s1_addr_reg [NUM_BANKS];
    logic [3:0]               s1_sel_reg;
    logic [FRAC_W-1:0]        s1_fx_reg, s1_fy_reg;

    // stage 2: bank read data
    logic [TEXEL_W-1:0]       bank_mem [NUM_BANKS][BANK_DEPTH];
    logic [TEXEL_W-1:0]       s2_rd_reg [NUM_BANKS];
    logic                     s2_valid_reg;
    logic [3:0]               s2_sel_reg;
    logic [FRAC_W-1:0]        s2_fx_reg, s2_fy_reg;

    // stage 3: horizontal blend
    logic [15:0]              r0_next [NUM_CHAN];
    logic [15:0]              r1_next [NUM_CHAN];
    logic [15:0]              s3_r0_reg [NUM_CHAN];
    logic [15:0]              s3_r1_reg [NUM_CHAN];
    logic                     s3_valid_reg;
    logic [FRAC_W-1:0]        s3_fy_reg;

    // stage 4: vertical blend and round
    logic [CHAN_W-1:0]        chan_next [NUM_CHAN];
    logic [CHAN_W-1:0]        out_reg [NUM_CHAN];
    logic                     rsp_valid_reg;

    assign advance   = !rsp_valid_reg || rsp_ready;
    assign q_pop     = advance && !q_empty;
    assign rsp_valid = rsp_valid_reg;
    assign rsp.out_red   = out_reg[0];
    assign rsp.out_green = out_reg[1];
    assign rsp.out_blue  = out_reg[2];
    assign rsp.out_alpha = out_reg[3];

    always_comb
    begin
        // bilinear shifts back by half a texel, point mode floors directly
        hx = q_entry.sx - ((cfg.mode == MODE_BILINEAR) ? HALF_TEXEL : '0);
        hy = q_entry.sy - ((cfg.mode == MODE_BILINEAR) ? HALF_TEXEL : '0);
        xi = hx >>> UV_FRAC_BITS;
        yi = hy >>> UV_FRAC_BITS;
        x0 = clamp_coord(xi, cfg.width);
        x1 = clamp_coord(xi + 1'b1, cfg.width);
        y0 = clamp_coord(yi, cfg.height);
        y1 = clamp_coord(yi + 1'b1, cfg.height);
        fx_next = (cfg.mode == MODE_BILINEAR) ? hx[UV_FRAC_BITS-1 -: FRAC_W] : '0;
        fy_next = (cfg.mode == MODE_BILINEAR) ? hy[UV_FRAC_BITS-1 -: FRAC_W] : '0;
        wr_ok = (q_entry.kind == KIND_WRITE)
             && (32'(q_entry.wx) < MAX_WIDTH) && (32'(q_entry.wy) < MAX_HEIGHT);
        waddr = bank_addr(SIZE_W'(q_entry.wx), SIZE_W'(q_entry.wy));
        // banks are split by column and row parity
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            if (q_entry.kind == KIND_WRITE)
                addr_next[b] = waddr;
            else
                addr_next[b] = bank_addr((x0[0] == b[0]) ? x0 : x1,
                                         (y0[0] == b[1]) ? y0 : y1);
        end
        sel_next = {y1[0], y0[0], x1[0], x0[0]};
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            r0_next[c] = 16'(s2_rd_reg[{s2_sel_reg[2], s2_sel_reg[0]}][CHAN_W*c +: CHAN_W])
                       * 16'(9'd256 - {1'b0, s2_fx_reg})
                       + 16'(s2_rd_reg[{s2_sel_reg[2], s2_sel_reg[1]}][CHAN_W*c +: CHAN_W])
                       * 16'(s2_fx_reg);
            r1_next[c] = 16'(s2_rd_reg[{s2_sel_reg[3], s2_sel_reg[0]}][CHAN_W*c +: CHAN_W])
                       * 16'(9'd256 - {1'b0, s2_fx_reg})
                       + 16'(s2_rd_reg[{s2_sel_reg[3], s2_sel_reg[1]}][CHAN_W*c +: CHAN_W])
                       * 16'(s2_fx_reg);
        end
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            chan_next[c] = 8'((25'(24'(s3_r0_reg[c]) * 24'(9'd256 - {1'b0, s3_fy_reg})
                             + 24'(s3_r1_reg[c]) * 24'(s3_fy_reg)) + 25'd32768) >> 16);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= q_pop;
            s2_valid_reg  <= s1_valid_reg && (s1_kind_reg == KIND_SAMPLE);
            s3_valid_reg  <= s2_valid_reg;
            rsp_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_kind_reg  <= q_entry.kind;
            s1_wr_reg    <= wr_ok;
            s1_wbank_reg <= {q_entry.wy[0], q_entry.wx[0]};
            s1_texel_reg <= q_entry.texel;
            s1_addr_reg  <= addr_next;
            s1_sel_reg   <= sel_next;
            s1_fx_reg    <= fx_next;
            s1_fy_reg    <= fy_next;
            s2_sel_reg   <= s1_sel_reg;
            s2_fx_reg    <= s1_fx_reg;
            s2_fy_reg    <= s1_fy_reg;
            s3_r0_reg    <= r0_next;
            s3_r1_reg    <= r1_next;
            s3_fy_reg    <= s2_fy_reg;
            out_reg      <= chan_next;
        end
    end

    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        always_ff @(posedge clk)
        begin
            if (advance && s1_valid_reg && s1_wr_reg && (s1_wbank_reg == 2'(b)))
            begin
                bank_mem[b][s1_addr_reg[b]] <= s1_texel_reg;
            end
            if (advance)
            begin
                s2_rd_reg[b] <= bank_mem[b][s1_addr_reg[b]];
            end
        end
    end

endmodule

### hw/rtl/texture_sampler_point_bilinear_unit.sv
// texture sampler with nearest point and bilinear filtering, clamp to edge
// request channel (req_valid, req_ready, req): kind 0 writes one rgba8 texel
// at write_x, write_y; kind 1 samples at signed fixed point u_coord, v_coord
// response channel (rsp_valid, rsp_ready, rsp): one filtered rgba8 result per
// sample request, none for texel writes, in request order
// config port (write_en, reg_index, write_data): width, height and filter mode,
// the user writes it only while no request is in flight; the block has no check
// throughput: one request per cycle unless the receiver stalls; the texel store is
// in four banks by column and row parity, so all four bilinear taps read at once
// from request to response the data passes the front scale register, the queue
// slot, the address stage, the bank read and two blend stages
// receiver stall freezes the back pipeline; the queue between front and back
// absorbs in-flight requests, then req_ready drops once queue and front fill
// reset clears control and config (width and height 128, point mode); texel
// contents are undefined until written and no clearing pass is run
module texture_sampler_point_bilinear_unit
    import tsp_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
    parameter int UV_FRAC_BITS = DEF_UV_FRAC_BITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rsp_t              rsp,
    input  logic              write_en,
    input  cfg_index_t        reg_index,
    input  logic [SIZE_W-1:0] write_data
);

    // configuration registers
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic              mode_reg;
    cfg_t              cfg;

    // front to queue to back
    logic   q_push, q_full, q_pop, q_empty;
    entry_t push_entry, pop_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_W'(128);
            height_reg <= SIZE_W'(128);
            mode_reg   <= MODE_POINT;
        end
        else if (write_en)
        begin
            case (reg_index)
                CFG_WIDTH:  width_reg  <= write_data;
                CFG_HEIGHT: height_reg <= write_data;
                CFG_MODE:   mode_reg   <= write_data[0];
                default:    ;
            endcase
        end
    end

    // effective sizes: zero acts as one, anything above the store acts as its max
    always_comb
    begin
        if (width_reg == '0)
            cfg.width = SIZE_W'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            cfg.width = SIZE_W'(MAX_WIDTH);
        else
            cfg.width = width_reg;
        if (height_reg == '0)
            cfg.height = SIZE_W'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            cfg.height = SIZE_W'(MAX_HEIGHT);
        else
            cfg.height = height_reg;
        cfg.mode = mode_reg;
    end

    // front: accept and scale coordinates
    tsp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cfg       (cfg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (push_entry)
    );

    // short queue lets front and back stall independently
    tsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .pop_entry  (pop_entry)
    );

    // back: texel writes, banked fetch and blend
    tsp_back #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .UV_FRAC_BITS (UV_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_empty   (q_empty),
        .q_entry   (pop_entry),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
